/* rtl/core/siwf_pkg.sv */
// Shared types and constants of the stereo iterative wavefolder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package siwf_pkg;

  // Field and register widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned KNOB_W     = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned FOLD_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Default iteration limit of the mono path.
  localparam int unsigned FOLD_LIMIT_DEFAULT = 100;

  // Clamp limits of the summed controls: gain 0..20 V, fold 0..10 V.
  localparam int unsigned GAIN_MAX = 40960;
  localparam int unsigned FOLD_MAX = 20480;

  // Internal folding value in units of 2^-22 V, and the folded excess.
  localparam int unsigned V_W    = 44;
  localparam int unsigned E_W    = 40;
  localparam int unsigned EL_W   = 20;
  localparam int unsigned RES_W  = 26;
  localparam int unsigned MIX_W  = RES_W + 1;
  localparam int unsigned GPROD_W = 32;

  localparam logic signed [V_W-1:0] RAIL     = 44'sd20971520;
  localparam logic signed [V_W-1:0] NEG_RAIL = -44'sd20971520;
  localparam logic signed [V_W-1:0] SAT      = 44'sd1099511627776;
  localparam logic signed [V_W-1:0] NEG_SAT  = -44'sd1099511627776;

  // Shared multiplier and the divide-by-10240 datapath.
  localparam int unsigned MUL_W    = 25;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned PP_W     = EL_W + FOLD_W;
  localparam int unsigned PSUM_W   = PP_W + EL_W;
  localparam int unsigned DIV_SH   = 11;
  localparam int unsigned B_W      = PSUM_W - DIV_SH;
  localparam int unsigned BLO_W    = 22;
  localparam int unsigned Q1_W     = 20;
  localparam int unsigned Q2_W     = 22;
  localparam int unsigned REM_W    = 3;
  localparam int unsigned RECIP_SH = 27;
  localparam logic [MUL_W-1:0] RECIP5 = 25'd26843546;

  // Output rounding: 2^-22 V down to 1/2048 V.
  localparam int unsigned ROUND_SH = 11;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_KNOB         = 3'd0,
    CFG_FOLD_KNOB         = 3'd1,
    CFG_LEFT_IN_PRESENT   = 3'd2,
    CFG_RIGHT_IN_PRESENT  = 3'd3,
    CFG_LEFT_OUT_PRESENT  = 3'd4,
    CFG_RIGHT_OUT_PRESENT = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [KNOB_W-1:0] gain_knob;
    logic [KNOB_W-1:0] fold_knob;
    logic              left_in_present;
    logic              right_in_present;
    logic              left_out_present;
    logic              right_out_present;
  } cfg_t;

  // Folded values of both sides, within the rails.
  typedef struct packed {
    logic signed [RES_W-1:0] left;
    logic signed [RES_W-1:0] right;
  } res_t;

endpackage

`default_nettype wire

/* rtl/core/siwf_cfg.sv */
// Configuration register file of the stereo iterative wavefolder.
// Depends on siwf_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module siwf_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              we_i,
  input  wire logic [siwf_pkg::CFG_IDX_W-1:0]    idx_i,
  input  wire logic [siwf_pkg::CFG_DATA_W-1:0]   data_i,
  output siwf_pkg::cfg_t                         cfg_o
);

  siwf_pkg::cfg_t cfg_q;

  // One register per index; writes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_knob         <= siwf_pkg::KNOB_W'(2048);
      cfg_q.fold_knob         <= '0;
      cfg_q.left_in_present   <= 1'b0;
      cfg_q.right_in_present  <= 1'b0;
      cfg_q.left_out_present  <= 1'b0;
      cfg_q.right_out_present <= 1'b0;
    end else if (we_i) begin
      unique case (siwf_pkg::cfg_idx_e'(idx_i))
        siwf_pkg::CFG_GAIN_KNOB:         cfg_q.gain_knob <= data_i[siwf_pkg::KNOB_W-1:0];
        siwf_pkg::CFG_FOLD_KNOB:         cfg_q.fold_knob <= data_i[siwf_pkg::KNOB_W-1:0];
        siwf_pkg::CFG_LEFT_IN_PRESENT:   cfg_q.left_in_present <= data_i[0];
        siwf_pkg::CFG_RIGHT_IN_PRESENT:  cfg_q.right_in_present <= data_i[0];
        siwf_pkg::CFG_LEFT_OUT_PRESENT:  cfg_q.left_out_present <= data_i[0];
        siwf_pkg::CFG_RIGHT_OUT_PRESENT: cfg_q.right_out_present <= data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/siwf_mul.sv */
// Shared unsigned multiplier of the wavefolder with a registered product.
// Depends on siwf_pkg for the operand and product widths.
`default_nettype none

module siwf_mul (
  input  wire logic                          clk_i,
  input  wire logic [siwf_pkg::MUL_W-1:0]    a_i,
  input  wire logic [siwf_pkg::MUL_W-1:0]    b_i,
  output logic      [siwf_pkg::PROD_W-1:0]   prod_o
);

  logic [siwf_pkg::PROD_W-1:0] prod_q;

  // The product is ready in the cycle after the operands are issued.
  always_ff @(posedge clk_i) begin
    prod_q <= siwf_pkg::PROD_W'(a_i) * siwf_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* rtl/core/siwf_core.sv */
// Folding sequencer: gains each side, then folds it at the rails with the
// shared multiplier. Depends on siwf_pkg and instantiates siwf_mul.
`default_nettype none

module siwf_core #(
  parameter int unsigned FOLD_LIMIT = siwf_pkg::FOLD_LIMIT_DEFAULT
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic signed [siwf_pkg::SAMPLE_W-1:0]   left_i,
  input  wire logic signed [siwf_pkg::SAMPLE_W-1:0]   right_i,
  input  wire logic        [siwf_pkg::GAIN_W-1:0]     gain_i,
  input  wire logic        [siwf_pkg::FOLD_W-1:0]     fold_i,
  input  siwf_pkg::cfg_t                              cfg_i,
  output logic                                        idle_o,
  output logic                                        res_valid_o,
  input  wire logic                                   res_ready_i,
  output siwf_pkg::res_t                              res_o
);

  localparam int unsigned ITER_W = $clog2(FOLD_LIMIT + 1);
  localparam logic [ITER_W-1:0] LIM_MONO   = ITER_W'(FOLD_LIMIT);
  localparam logic [ITER_W-1:0] LIM_STEREO = ITER_W'(FOLD_LIMIT - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_GMUL, ST_GLOAD, ST_CHK, ST_ML, ST_MH, ST_ACC,
    ST_D1, ST_D2, ST_UPD, ST_DONE
  } state_e;

  state_e state_q;

  logic signed [siwf_pkg::SAMPLE_W-1:0] l_q, r_q;
  logic [siwf_pkg::GAIN_W-1:0]          gain_q;
  logic [siwf_pkg::FOLD_W-1:0]          fold_q;
  logic                                 side_q, two_q, neg_q, below_q;
  logic [ITER_W-1:0]                    iter_q, lim_q;
  logic signed [siwf_pkg::V_W-1:0]      v_q;
  logic [siwf_pkg::E_W-1:0]             e_q;
  logic [siwf_pkg::PP_W-1:0]            acc_q;
  logic [siwf_pkg::B_W-1:0]             b_q;
  logic [siwf_pkg::Q1_W-1:0]            q1_q;
  logic signed [siwf_pkg::RES_W-1:0]    lres_q, rres_q;

  logic [siwf_pkg::MUL_W-1:0]           mul_a, mul_b;
  logic [siwf_pkg::PROD_W-1:0]          prod;

  logic signed [siwf_pkg::SAMPLE_W-1:0] smp;
  logic [siwf_pkg::SAMPLE_W-1:0]        smp_mag;
  logic signed [siwf_pkg::V_W-1:0]      gval;
  logic                                 chk_blown, chk_within, chk_fin;
  logic signed [siwf_pkg::RES_W-1:0]    chk_res;
  logic signed [siwf_pkg::V_W-1:0]      chk_exc;
  logic [siwf_pkg::PSUM_W-1:0]          psum;
  logic [siwf_pkg::Q1_W-1:0]            q1;
  logic [siwf_pkg::REM_W-1:0]           q1x5_lo, rem1;
  logic [siwf_pkg::MUL_W-1:0]           x2;
  logic signed [siwf_pkg::V_W-1:0]      quo;

  siwf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Sample of the side being worked on; one connected input feeds both sides.
  assign smp     = two_q ? (side_q ? r_q : l_q) : (cfg_i.left_in_present ? l_q : r_q);
  assign smp_mag = smp[siwf_pkg::SAMPLE_W-1] ? (~smp + 1'b1) : smp;
  assign gval    = $signed({{(siwf_pkg::V_W - siwf_pkg::GPROD_W){1'b0}},
                            prod[siwf_pkg::GPROD_W-1:0]});

  // Iteration decisions on the current value.
  assign chk_blown  = (v_q > siwf_pkg::SAT) || (v_q < siwf_pkg::NEG_SAT);
  assign chk_within = (v_q >= siwf_pkg::NEG_RAIL) && (v_q <= siwf_pkg::RAIL);
  assign chk_fin    = chk_blown || chk_within || (iter_q == lim_q);
  assign chk_res    = chk_within ? v_q[siwf_pkg::RES_W-1:0] : '0;
  assign chk_exc    = v_q[siwf_pkg::V_W-1] ? (siwf_pkg::NEG_RAIL - v_q)
                                           : (v_q - siwf_pkg::RAIL);

  // Excess times fold from its two partial products, then divided by 2048.
  assign psum = {prod[siwf_pkg::PP_W-1:0], {siwf_pkg::EL_W{1'b0}}}
              + siwf_pkg::PSUM_W'(acc_q);

  // Long division by five in two chunks: only the low remainder bits matter.
  assign q1      = prod[siwf_pkg::RECIP_SH + siwf_pkg::Q1_W - 1:siwf_pkg::RECIP_SH];
  assign q1x5_lo = q1[siwf_pkg::REM_W-1:0] + {q1[0], 2'b00};
  assign rem1    = b_q[siwf_pkg::BLO_W + siwf_pkg::REM_W - 1:siwf_pkg::BLO_W] - q1x5_lo;
  assign x2      = {rem1, b_q[siwf_pkg::BLO_W-1:0]};
  assign quo     = $signed({{(siwf_pkg::V_W - siwf_pkg::Q1_W - siwf_pkg::Q2_W){1'b0}}, q1_q,
                   prod[siwf_pkg::RECIP_SH + siwf_pkg::Q2_W - 1:siwf_pkg::RECIP_SH]});

  // Operands of the shared multiplier in each step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_GMUL: begin
        mul_a = siwf_pkg::MUL_W'(smp_mag);
        mul_b = siwf_pkg::MUL_W'(gain_q);
      end
      ST_ML: begin
        mul_a = siwf_pkg::MUL_W'(e_q[siwf_pkg::EL_W-1:0]);
        mul_b = siwf_pkg::MUL_W'(fold_q);
      end
      ST_MH: begin
        mul_a = siwf_pkg::MUL_W'(e_q[siwf_pkg::E_W-1:siwf_pkg::EL_W]);
        mul_b = siwf_pkg::MUL_W'(fold_q);
      end
      ST_D1: begin
        mul_a = siwf_pkg::MUL_W'(b_q[siwf_pkg::B_W-1:siwf_pkg::BLO_W]);
        mul_b = siwf_pkg::RECIP5;
      end
      ST_D2: begin
        mul_a = x2;
        mul_b = siwf_pkg::RECIP5;
      end
      default: begin
      end
    endcase
  end

  // Sequencer with its datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      l_q     <= '0;
      r_q     <= '0;
      gain_q  <= '0;
      fold_q  <= '0;
      side_q  <= 1'b0;
      two_q   <= 1'b0;
      neg_q   <= 1'b0;
      below_q <= 1'b0;
      iter_q  <= '0;
      lim_q   <= '0;
      v_q     <= '0;
      e_q     <= '0;
      acc_q   <= '0;
      b_q     <= '0;
      q1_q    <= '0;
      lres_q  <= '0;
      rres_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            l_q    <= left_i;
            r_q    <= right_i;
            gain_q <= gain_i;
            fold_q <= fold_i;
            side_q <= 1'b0;
            two_q  <= cfg_i.left_in_present & cfg_i.right_in_present;
            if (cfg_i.left_in_present | cfg_i.right_in_present) begin
              state_q <= ST_GMUL;
            end else begin
              lres_q  <= '0;
              rres_q  <= '0;
              state_q <= ST_DONE;
            end
          end
        end
        ST_GMUL: begin
          neg_q   <= smp[siwf_pkg::SAMPLE_W-1];
          iter_q  <= '0;
          lim_q   <= two_q ? LIM_STEREO : LIM_MONO;
          state_q <= ST_GLOAD;
        end
        ST_GLOAD: begin
          v_q     <= neg_q ? -gval : gval;
          state_q <= ST_CHK;
        end
        ST_CHK: begin
          if (chk_fin) begin
            if (!two_q) begin
              lres_q  <= chk_res;
              rres_q  <= chk_res;
              state_q <= ST_DONE;
            end else if (!side_q) begin
              lres_q  <= chk_res;
              side_q  <= 1'b1;
              state_q <= ST_GMUL;
            end else begin
              rres_q  <= chk_res;
              state_q <= ST_DONE;
            end
          end else begin
            below_q <= v_q[siwf_pkg::V_W-1];
            e_q     <= chk_exc[siwf_pkg::E_W-1:0];
            state_q <= ST_ML;
          end
        end
        ST_ML: begin
          state_q <= ST_MH;
        end
        ST_MH: begin
          acc_q   <= prod[siwf_pkg::PP_W-1:0];
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          b_q     <= psum[siwf_pkg::PSUM_W-1:siwf_pkg::DIV_SH];
          state_q <= ST_D1;
        end
        ST_D1: begin
          state_q <= ST_D2;
        end
        ST_D2: begin
          q1_q    <= q1;
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          // A fold from below reflects upwards; one from above ends the iteration.
          v_q <= below_q ? (quo - siwf_pkg::RAIL) : (siwf_pkg::RAIL - quo);
          if (!below_q) begin
            iter_q <= iter_q + ITER_W'(1);
          end
          state_q <= ST_CHK;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o.left  = lres_q;
  assign res_o.right = rres_q;

  // The iteration count never passes the limit of the side.
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= lim_q)
    else $error("fold iteration count beyond its limit");

  // A fold never leaves the value beyond the rail it folded at.
  a_fold_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |=>
      ($past(below_q) ? (v_q >= siwf_pkg::NEG_RAIL) : (v_q <= siwf_pkg::RAIL)))
    else $error("fold overshot its own rail");

  // Results offered to the output stage lie within the rails.
  a_res_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |->
      (siwf_pkg::V_W'(lres_q) >= siwf_pkg::NEG_RAIL) &&
      (siwf_pkg::V_W'(lres_q) <= siwf_pkg::RAIL) &&
      (siwf_pkg::V_W'(rres_q) >= siwf_pkg::NEG_RAIL) &&
      (siwf_pkg::V_W'(rres_q) <= siwf_pkg::RAIL))
    else $error("result outside the rails");

endmodule

`default_nettype wire

/* rtl/core/stereo_iterative_wavefolder.sv */
// Top level of the stereo iterative wavefolder: stream ports, control
// clamping, output mixing and rounding. Depends on siwf_pkg, siwf_cfg, siwf_core.
//
// One item carries a left and right sample with gain and fold control
// voltages; one result item with both folded sides comes back for each.
// Items are taken one at a time: s_axis_tready is high only while the core
// is idle, and a finished result waits in the output register so the next
// item can be taken meanwhile. An item takes the core through IDLE and
// DONE, through GMUL, GLOAD and a last CHK for each side folded (none, one,
// or two when both inputs are connected), and through CHK, ML, MH, ACC, D1,
// D2 and UPD for each fold operation; with no input connected it goes from
// IDLE straight to DONE. This sequence is set by the single shared 25x25
// multiplier, which issues four products per fold (two partial products of
// excess times fold, two reciprocal steps of the division by five). At most
// two folds run per iteration; with both inputs each side stops after at
// most FOLD_LIMIT - 1 iterations, with one input after FOLD_LIMIT.
`default_nettype none

module stereo_iterative_wavefolder #(
  parameter int unsigned FOLD_LIMIT = siwf_pkg::FOLD_LIMIT_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [siwf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [siwf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // left_in [15:0], right_in [31:16], gain_cv [47:32], fold_cv [63:48]
  input  wire logic [4*siwf_pkg::SAMPLE_W-1:0]     s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // left_out [15:0], right_out [31:16]
  output logic      [2*siwf_pkg::SAMPLE_W-1:0]     m_axis_tdata
);

  localparam int unsigned SUM_W = siwf_pkg::SAMPLE_W + 2;

  siwf_pkg::cfg_t cfg;
  siwf_pkg::res_t res;

  logic                                 start, core_idle, res_valid, res_take;
  logic signed [siwf_pkg::SAMPLE_W-1:0] left_in, right_in, gain_cv, fold_cv;
  logic signed [SUM_W-1:0]              gain_sum, fold_sum;
  logic [siwf_pkg::GAIN_W-1:0]          gain_cl;
  logic [siwf_pkg::FOLD_W-1:0]          fold_cl;
  logic                                 in_single, out_single;
  logic signed [siwf_pkg::MIX_W-1:0]    l_ext, r_ext, mix;
  logic [siwf_pkg::SAMPLE_W-1:0]        left_f, right_f;
  logic                                 m_valid_q;
  logic [2*siwf_pkg::SAMPLE_W-1:0]      m_data_q;

  // Round to nearest 1/2048 V, ties towards plus infinity, and wrap to 16 bits.
  function automatic logic [siwf_pkg::SAMPLE_W-1:0] to_field(
    input logic signed [siwf_pkg::MIX_W-1:0] x
  );
    logic signed [siwf_pkg::MIX_W:0] t;
    t = {x[siwf_pkg::MIX_W-1], x} + (siwf_pkg::MIX_W + 1)'(1024);
    return t[siwf_pkg::SAMPLE_W + siwf_pkg::ROUND_SH - 1:siwf_pkg::ROUND_SH];
  endfunction

  siwf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Unpack the input item.
  assign left_in  = s_axis_tdata[siwf_pkg::SAMPLE_W-1:0];
  assign right_in = s_axis_tdata[2*siwf_pkg::SAMPLE_W-1:siwf_pkg::SAMPLE_W];
  assign gain_cv  = s_axis_tdata[3*siwf_pkg::SAMPLE_W-1:2*siwf_pkg::SAMPLE_W];
  assign fold_cv  = s_axis_tdata[4*siwf_pkg::SAMPLE_W-1:3*siwf_pkg::SAMPLE_W];

  // Knob plus control voltage, clamped to the allowed range.
  assign gain_sum = $signed(SUM_W'(cfg.gain_knob)) + SUM_W'(gain_cv);
  assign fold_sum = $signed(SUM_W'(cfg.fold_knob)) + SUM_W'(fold_cv);

  always_comb begin
    priority if (gain_sum < 0) begin
      gain_cl = '0;
    end else if (gain_sum > $signed(SUM_W'(siwf_pkg::GAIN_MAX))) begin
      gain_cl = siwf_pkg::GAIN_W'(siwf_pkg::GAIN_MAX);
    end else begin
      gain_cl = gain_sum[siwf_pkg::GAIN_W-1:0];
    end
    priority if (fold_sum < 0) begin
      fold_cl = '0;
    end else if (fold_sum > $signed(SUM_W'(siwf_pkg::FOLD_MAX))) begin
      fold_cl = siwf_pkg::FOLD_W'(siwf_pkg::FOLD_MAX);
    end else begin
      fold_cl = fold_sum[siwf_pkg::FOLD_W-1:0];
    end
  end

  assign s_axis_tready = core_idle;
  assign start         = s_axis_tvalid & core_idle;

  siwf_core #(
    .FOLD_LIMIT (FOLD_LIMIT)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .left_i      (left_in),
    .right_i     (right_in),
    .gain_i      (gain_cl),
    .fold_i      (fold_cl),
    .cfg_i       (cfg),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res)
  );

  // A single connected output carries the mix of both sides.
  assign in_single  = cfg.left_in_present ^ cfg.right_in_present;
  assign out_single = cfg.left_out_present ^ cfg.right_out_present;
  assign l_ext      = siwf_pkg::MIX_W'(res.left);
  assign r_ext      = siwf_pkg::MIX_W'(res.right);
  assign mix        = in_single ? l_ext : (l_ext + r_ext);
  assign left_f     = out_single ? to_field(mix) : to_field(l_ext);
  assign right_f    = out_single ? to_field(mix) : to_field(r_ext);

  // Output register: takes a result whenever it is empty or being emptied.
  assign res_take = res_valid & (~m_valid_q | m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
      m_data_q  <= {right_f, left_f};
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire
